/* rtl/assert_macros.svh */
// Assertion helper macros for the block map allocator RTL.
// Included by modules that carry concurrent checks; compiled out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define BMA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define BMA_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BMA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BMA_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* rtl/bma_pkg.sv */
// Shared constants, types and codes for the block map allocator.
// No dependencies; imported by the interfaces and the top level.
`timescale 1ns / 1ps

package bma_pkg;

	localparam int MAP_ENTRIES = 256;
	localparam int BLOCK_BYTES = 65536;

	localparam int BLK_W      = $clog2(MAP_ENTRIES);
	localparam int SLOT_W     = BLK_W + 1;
	localparam int OFS_W      = 48;
	localparam int DOFS_W     = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DOFS_W;

	// bitmap search is split into groups: encode inside groups, then pick a group
	localparam int GRP_SIZE = 16;
	localparam int GRP_CNT  = MAP_ENTRIES / GRP_SIZE;
	localparam int GIDX_W   = $clog2(GRP_SIZE);
	localparam int GSEL_W   = $clog2(GRP_CNT);

	typedef logic [1:0] mode_t;
	typedef logic [1:0] status_t;

	localparam mode_t MODE_LOOKUP = 2'd0;
	localparam mode_t MODE_ALLOC  = 2'd1;
	localparam mode_t MODE_FREE   = 2'd2;
	localparam mode_t MODE_CLEAR  = 2'd3;

	localparam status_t ST_OK          = 2'd0;
	localparam status_t ST_NOT_MAPPED  = 2'd1;
	localparam status_t ST_NO_SPACE    = 2'd2;
	localparam status_t ST_ALREADY_MAP = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_OFFSET = 2'd2;

	localparam logic [SLOT_W-1:0] SLOT_COUNT_RST = SLOT_W'(MAP_ENTRIES);

endpackage

/* rtl/bma_req_if.sv */
// Request channel: valid/ready handshake carrying mode and logical block.
// Depends on bma_pkg.
`timescale 1ns / 1ps

interface bma_req_if import bma_pkg::*; ();
	logic             valid;
	logic             ready;
	mode_t            mode;
	logic [BLK_W-1:0] logical_block;

	modport source (output valid, output mode, output logical_block, input ready);
	modport sink   (input valid, input mode, input logical_block, output ready);
endinterface

/* rtl/bma_rsp_if.sv */
// Response channel: valid/ready handshake carrying status, slot and byte offset.
// Depends on bma_pkg.
`timescale 1ns / 1ps

interface bma_rsp_if import bma_pkg::*; ();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [SLOT_W-1:0] physical_slot;
	logic [OFS_W-1:0]  byte_offset;

	modport source (output valid, output status, output physical_slot, output byte_offset,
		input ready);
	modport sink   (input valid, input status, input physical_slot, input byte_offset,
		output ready);
endinterface

/* rtl/block_map_allocator_top.sv */
// Block map allocator: maps logical blocks to physical cache-file slots.
// Depends on bma_pkg, bma_req_if, bma_rsp_if and assert_macros.svh.
//
// Requests enter on req (lookup, allocate, free, clear all); each gives one item on rsp.
// The user must write registers through cfg_we/cfg_index/cfg_wdata only while idle;
// the block itself does not enforce it. Steps: accept -> map read and bitmap group
// encode -> decide and write back (S_EXEC) -> slot times block size (S_MUL) -> add
// data offset into the output register (S_FIN). The four steps run one after another
// and the next item waits until the last one is done.
// req.ready is high only while no item is in flight, so map accesses never overlap.
// A result waiting in the output register does not block the next accept; the
// item behind it holds in its last step until rsp.ready frees the register.
// Clear all runs through the same steps: valid bits of map and bitmap drop at once.
// Reset: map empty, all slots free, serial_mode 0, slot_count 256, data_offset 0.
// No clearing pass after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module block_map_allocator_top import bma_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	bma_req_if.sink               req,
	bma_rsp_if.source             rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_MUL  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;

	// configuration
	logic              serial_q;
	logic [SLOT_W-1:0] slot_count_q;
	logic [DOFS_W-1:0] data_ofs_q;

	// request
	mode_t            mode_q;
	logic [BLK_W-1:0] blk_q;

	// map memory with per-entry valid bits, bitmap in flops
	logic [SLOT_W-1:0]      map_mem [MAP_ENTRIES];
	logic [MAP_ENTRIES-1:0] map_vld_q;
	logic [MAP_ENTRIES-1:0] used_q;
	logic [SLOT_W-1:0]      rd_data_s1;
	logic                   rd_vld_s1;

	logic [MAP_ENTRIES-1:0] free_vec;
	logic [GRP_CNT-1:0]     grp_any;
	logic [GIDX_W-1:0]      grp_idx [GRP_CNT];
	logic [GRP_CNT-1:0]     grp_any_s1;
	logic [GIDX_W-1:0]      grp_idx_s1 [GRP_CNT];

	logic              accept;
	logic              exec;
	logic              fin_load;
	logic [GSEL_W-1:0] sel_g;
	logic              any_free;
	logic [BLK_W-1:0]  found_slot;
	logic [SLOT_W-1:0] entry;
	logic [SLOT_W-1:0] entry_m1;

	status_t           res_status;
	logic [SLOT_W-1:0] res_slot;
	logic              res_ofs_en;
	logic              map_set;
	logic              map_clr;
	logic              clear_all;

	status_t           status_q;
	logic [SLOT_W-1:0] slot_q;
	logic              ofs_en_q;
	logic [OFS_W-1:0]  prod_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [OFS_W-1:0]  out_ofs_q;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign exec      = (state_q == S_EXEC);
	assign fin_load  = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.physical_slot = out_slot_q;
	assign rsp.byte_offset   = out_ofs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_q     <= 1'b0;
			slot_count_q <= SLOT_COUNT_RST;
			data_ofs_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SERIAL_MODE: serial_q     <= cfg_wdata[0];
				CFG_SLOT_COUNT:  slot_count_q <= cfg_wdata[SLOT_W-1:0];
				CFG_DATA_OFFSET: data_ofs_q   <= cfg_wdata[DOFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: state_q <= S_MUL;
				S_MUL:  state_q <= S_FIN;
				S_FIN:  if (fin_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// slots at or above slot_count are never handed out
	always_comb begin
		for (int i = 0; i < MAP_ENTRIES; i++)
			free_vec[i] = !used_q[i] && (SLOT_W'(i) < slot_count_q);
	end

	always_comb begin
		for (int g = 0; g < GRP_CNT; g++) begin
			grp_any[g] = |free_vec[g*GRP_SIZE +: GRP_SIZE];
			grp_idx[g] = '0;
			for (int b = GRP_SIZE - 1; b >= 0; b--)
				if (free_vec[g*GRP_SIZE + b]) grp_idx[g] = GIDX_W'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= req.mode;
			blk_q      <= req.logical_block;
			rd_data_s1 <= map_mem[req.logical_block];
			rd_vld_s1  <= map_vld_q[req.logical_block];
			grp_any_s1 <= grp_any;
			for (int g = 0; g < GRP_CNT; g++)
				grp_idx_s1[g] <= grp_idx[g];
		end
		if (exec && map_set)
			map_mem[blk_q] <= {1'b0, found_slot} + 1'b1;
	end

	always_comb begin
		sel_g = '0;
		for (int g = GRP_CNT - 1; g >= 0; g--)
			if (grp_any_s1[g]) sel_g = GSEL_W'(g);
	end

	assign any_free   = |grp_any_s1;
	assign found_slot = {sel_g, grp_idx_s1[sel_g]};
	assign entry      = rd_vld_s1 ? rd_data_s1 : '0;
	assign entry_m1   = entry - 1'b1;

	always_comb begin
		res_status = ST_OK;
		res_slot   = '0;
		res_ofs_en = 1'b0;
		map_set    = 1'b0;
		map_clr    = 1'b0;
		clear_all  = 1'b0;
		if (mode_q == MODE_CLEAR) begin
			clear_all = 1'b1;
		end else if (serial_q) begin
			if (mode_q != MODE_FREE) begin
				res_slot   = {1'b0, blk_q} + 1'b1;
				res_ofs_en = 1'b1;
			end
		end else begin
			case (mode_q)
				MODE_LOOKUP: begin
					if (entry == '0) begin
						res_status = ST_NOT_MAPPED;
					end else begin
						res_slot   = entry;
						res_ofs_en = 1'b1;
					end
				end
				MODE_ALLOC: begin
					if (entry != '0) begin
						res_status = ST_ALREADY_MAP;
						res_slot   = entry;
					end else if (!any_free) begin
						res_status = ST_NO_SPACE;
					end else begin
						map_set    = 1'b1;
						res_slot   = {1'b0, found_slot} + 1'b1;
						res_ofs_en = 1'b1;
					end
				end
				MODE_FREE: begin
					if (entry == '0) begin
						res_status = ST_NOT_MAPPED;
					end else begin
						map_clr    = 1'b1;
						res_slot   = entry;
						res_ofs_en = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q <= '0;
			used_q    <= '0;
		end else if (exec) begin
			if (clear_all) begin
				map_vld_q <= '0;
				used_q    <= '0;
			end else if (map_set) begin
				map_vld_q[blk_q]      <= 1'b1;
				used_q[found_slot]    <= 1'b1;
			end else if (map_clr) begin
				map_vld_q[blk_q]          <= 1'b0;
				used_q[entry_m1[BLK_W-1:0]] <= 1'b0;
			end
		end
	end

	// result path: decide, scale slot, add base
	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			ofs_en_q <= res_ofs_en;
		end
		if (state_q == S_MUL)
			prod_q <= OFS_W'(SLOT_W'(slot_q - 1'b1)) * OFS_W'(BLOCK_BYTES);
		if (fin_load) begin
			out_status_q <= status_q;
			out_slot_q   <= slot_q;
			out_ofs_q    <= ofs_en_q ? (OFS_W'(data_ofs_q) + prod_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_load)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	// every mapped entry owns exactly one used slot
	`BMA_ASSERT(a_bitmap_match, clk, arst_n, $countones(used_q) == $countones(map_vld_q), "bitmap and map valid counts differ")
	// an allocation takes a free slot and leaves it marked used
	`BMA_ASSERT(a_alloc_marks, clk, arst_n, (exec && map_set) |=> used_q[$past(found_slot)], "allocated slot not marked used")
	`BMA_NEVER(a_alloc_taken, clk, arst_n, exec && map_set && used_q[found_slot], "allocation picked a used slot")
	`BMA_ASSERT(a_notmap_zero, clk, arst_n, (out_valid_q && (out_status_q == ST_NOT_MAPPED)) |-> ((out_slot_q == '0) && (out_ofs_q == '0)), "not-mapped result carries a slot")

endmodule
